FILE: hdl/ppcc_pkg.sv
// ----------------------------------------------------------------------------
// Palette pixel count classifier package
// Reference colours, reference counts, register map and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ppcc_pkg;

    // Default width of the dark and light tallies.
    localparam int COUNT_WIDTH = 16;

    // Fixed widths of the pixel and result fields.
    localparam int CHAN_W  = 8;
    localparam int CLASS_W = 4;
    localparam int TALLY_W = 16;

    // Reference counts are below 4096.
    localparam int REF_W = 12;

    // Squared distance over three channels: 3 * 255^2 fits in 18 bits.
    localparam int SQ_W  = 18;
    localparam int TOL_W = 8;
    localparam int TOLSQ_W = 2 * TOL_W;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_MATCH_TOL = 1'b0;
    localparam logic [TOL_W-1:0] MATCH_TOL_RESET = 8'd3;

    // Number of entries in each half of the reference table.
    localparam int HALF_N = 6;
    localparam int N_DARK  = 6;
    localparam int N_LIGHT = 2;

    // Three colour channels, index 0 is the first stored channel.
    typedef logic [0:2][CHAN_W-1:0] t_pixel;

    // Per-pixel match flags.
    typedef struct packed {
        logic dark;
        logic light;
    } t_match;

    localparam t_pixel DARK_COLOURS [0:N_DARK-1] = '{
        '{8'd82,  8'd83,  8'd86},
        '{8'd65,  8'd65,  8'd68},
        '{8'd115, 8'd115, 8'd118},
        '{8'd38,  8'd38,  8'd38},
        '{8'd117, 8'd117, 8'd120},
        '{8'd29,  8'd27,  8'd27}
    };

    localparam t_pixel LIGHT_COLOURS [0:N_LIGHT-1] = '{
        '{8'd248, 8'd248, 8'd248},
        '{8'd211, 8'd211, 8'd221}
    };

    // Pixel counts of a 104 x 104 tile; first half light, second half dark.
    localparam logic [REF_W-1:0] REF_COUNTS [0:2*HALF_N-1] = '{
        12'd1833, 12'd2065, 12'd1668, 12'd2267, 12'd2657, 12'd1001,
        12'd2686, 12'd3051, 12'd2503, 12'd3261, 12'd3442, 12'd1321
    };

    // Squared Euclidean distance between a pixel and a reference colour.
    function automatic logic [SQ_W-1:0] sq_dist(input t_pixel a, input t_pixel b);
        logic [CHAN_W-1:0]   d;
        logic [2*CHAN_W-1:0] sq;
        logic [SQ_W-1:0]     sum;
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            d   = (a[k] > b[k]) ? (a[k] - b[k]) : (b[k] - a[k]);
            sq  = d * d;
            sum = sum + SQ_W'(sq);
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ppcc_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel channel interface
// Valid/ready channel carrying one pixel and its end-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppcc_pix_if;
    logic                       valid;
    logic                       ready;
    logic [ppcc_pkg::CHAN_W-1:0] chan_zero;
    logic [ppcc_pkg::CHAN_W-1:0] chan_one;
    logic [ppcc_pkg::CHAN_W-1:0] chan_two;
    logic                       last_pixel;

    modport source (output valid, chan_zero, chan_one, chan_two, last_pixel, input ready);
    modport sink   (input valid, chan_zero, chan_one, chan_two, last_pixel, output ready);
endinterface

`default_nettype wire

FILE: hdl/ppcc_res_if.sv
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying the frame class and both tallies.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppcc_res_if;
    logic                         valid;
    logic                         ready;
    logic [ppcc_pkg::CLASS_W-1:0] piece_class;
    logic [ppcc_pkg::TALLY_W-1:0] dark_pixels;
    logic [ppcc_pkg::TALLY_W-1:0] light_pixels;

    modport source (output valid, piece_class, dark_pixels, light_pixels, input ready);
    modport sink   (input valid, piece_class, dark_pixels, light_pixels, output ready);
endinterface

`default_nettype wire

FILE: hdl/ppcc_match.sv
// ----------------------------------------------------------------------------
// Pixel colour matcher
// Compares one pixel with every dark and light reference colour in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module ppcc_match (
    input  wire ppcc_pkg::t_pixel                 i_pixel,
    input  wire logic [ppcc_pkg::TOLSQ_W-1:0]     i_tol_sq,
    output ppcc_pkg::t_match                      o_match
);

    logic [ppcc_pkg::N_DARK-1:0]  dark_hit;
    logic [ppcc_pkg::N_LIGHT-1:0] light_hit;

    // One distance check per reference colour; a match is strictly inside.
    always_comb begin
        for (int c = 0; c < ppcc_pkg::N_DARK; c++) begin
            dark_hit[c] = ppcc_pkg::sq_dist(i_pixel, ppcc_pkg::DARK_COLOURS[c])
                          < ppcc_pkg::SQ_W'(i_tol_sq);
        end
        for (int c = 0; c < ppcc_pkg::N_LIGHT; c++) begin
            light_hit[c] = ppcc_pkg::sq_dist(i_pixel, ppcc_pkg::LIGHT_COLOURS[c])
                           < ppcc_pkg::SQ_W'(i_tol_sq);
        end
    end

    assign o_match.dark  = |dark_hit;
    assign o_match.light = |light_hit;

endmodule

`default_nettype wire

FILE: hdl/palette_pixel_count_classifier.sv
// ----------------------------------------------------------------------------
// Palette pixel count classifier
// Tallies dark and light palette pixels of a frame and classifies the frame.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and never needs more: every pixel goes
// through an input register, a match register (eight parallel squared-distance
// compares against the tolerance) and the saturating tally counters. When the
// flagged last pixel has been counted, the final tallies pass through a
// distance stage and the minimum search into the result register driving the
// result channel. Only a frame end that finds the result stages full holds the
// pixel stream back; ordinary pixels keep flowing while a result waits to be
// taken. The user must write the tolerance register over the APB port at byte
// address 0 while no frame is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_pixel_count_classifier #(
    parameter int COUNT_WIDTH = ppcc_pkg::COUNT_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    ppcc_pix_if.sink                            i_pix,
    ppcc_res_if.source                          o_res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ppcc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ppcc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [ppcc_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);

    localparam int DIFF_W = (COUNT_WIDTH > ppcc_pkg::REF_W) ? COUNT_WIDTH : ppcc_pkg::REF_W;
    localparam int EXT_W  = (COUNT_WIDTH > ppcc_pkg::TALLY_W) ? COUNT_WIDTH
                                                              : ppcc_pkg::TALLY_W;
    localparam int IDX_W  = 3;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [ppcc_pkg::TOL_W-1:0]   r_tol;
    logic [ppcc_pkg::TOLSQ_W-1:0] r_tol_sq;
    logic                         cfg_wr;
    logic [0:0]                   cfg_idx;

    assign cfg_idx = paddr[2:2];
    assign cfg_wr  = psel && penable && pwrite && (cfg_idx == ppcc_pkg::REG_MATCH_TOL);
    assign pready  = 1'b1;
    assign prdata  = (cfg_idx == ppcc_pkg::REG_MATCH_TOL)
                   ? ppcc_pkg::PDATA_W'(r_tol) : '0;

    // The square of the tolerance is kept so the pixel path sees a constant.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= ppcc_pkg::MATCH_TOL_RESET;
            r_tol_sq <= ppcc_pkg::TOLSQ_W'(ppcc_pkg::MATCH_TOL_RESET
                                            * ppcc_pkg::MATCH_TOL_RESET);
        end else if (cfg_wr) begin
            r_tol    <= pwdata[ppcc_pkg::TOL_W-1:0];
            r_tol_sq <= pwdata[ppcc_pkg::TOL_W-1:0] * pwdata[ppcc_pkg::TOL_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_fin_valid, r_d_valid, r_out_valid;
    logic r_s1_last, r_s2_last;
    logic out_free, d_free, fin_free, fin_go, s2_go, s2_free, s1_go, s1_free;

    assign out_free = !r_out_valid || o_res.ready;
    assign d_free   = !r_d_valid || out_free;
    assign fin_go   = r_fin_valid && d_free;
    assign fin_free = !r_fin_valid || d_free;
    assign s2_go    = r_s2_valid && (!r_s2_last || fin_free);
    assign s2_free  = !r_s2_valid || s2_go;
    assign s1_go    = r_s1_valid && s2_free;
    assign s1_free  = !r_s1_valid || s1_go;

    assign i_pix.ready = s1_free;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    ppcc_pkg::t_pixel r_s1_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_pix.valid) begin
            r_s1_pixel <= '{i_pix.chan_zero, i_pix.chan_one, i_pix.chan_two};
            r_s1_last  <= i_pix.last_pixel;
        end
    end

    // ------------------------------------------------------------------
    // Match register
    // ------------------------------------------------------------------
    ppcc_pkg::t_match s1_match;
    ppcc_pkg::t_match r_s2_match;

    ppcc_match u_match (
        .i_pixel  (r_s1_pixel),
        .i_tol_sq (r_tol_sq),
        .o_match  (s1_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_match <= s1_match;
            r_s2_last  <= r_s1_last;
        end
    end

    // ------------------------------------------------------------------
    // Saturating tallies; a frame end moves them to the final registers.
    // ------------------------------------------------------------------
    logic [COUNT_WIDTH-1:0] r_dark, r_light, n_dark, n_light;
    logic [COUNT_WIDTH-1:0] r_fin_dark, r_fin_light;
    logic                   n_fin_valid;

    always_comb begin
        n_dark  = r_dark;
        n_light = r_light;
        if (r_s2_match.dark && (r_dark != '1)) begin
            n_dark = r_dark + COUNT_WIDTH'(1);
        end
        if (r_s2_match.light && (r_light != '1)) begin
            n_light = r_light + COUNT_WIDTH'(1);
        end
    end

    assign n_fin_valid = (r_fin_valid && !fin_go) || (s2_go && r_s2_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark      <= '0;
            r_light     <= '0;
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= n_fin_valid;
            if (s2_go) begin
                if (r_s2_last) begin
                    r_dark  <= '0;
                    r_light <= '0;
                end else begin
                    r_dark  <= n_dark;
                    r_light <= n_light;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && r_s2_last) begin
            r_fin_dark  <= n_dark;
            r_fin_light <= n_light;
        end
    end

    // ------------------------------------------------------------------
    // Distance stage: pick the half and measure against its six counts.
    // ------------------------------------------------------------------
    logic [DIFF_W-1:0]           r_diff [0:ppcc_pkg::HALF_N-1];
    logic                        r_d_dark_half;
    logic [ppcc_pkg::TALLY_W-1:0] r_d_dark, r_d_light;
    logic                        dark_half;
    logic [DIFF_W-1:0]           sel_count, ref_val;
    logic [DIFF_W-1:0]           n_diff [0:ppcc_pkg::HALF_N-1];
    logic [EXT_W-1:0]            fin_dark_ext, fin_light_ext;

    assign dark_half     = r_fin_dark > r_fin_light;
    assign sel_count     = dark_half ? DIFF_W'(r_fin_dark) : DIFF_W'(r_fin_light);
    assign fin_dark_ext  = EXT_W'(r_fin_dark);
    assign fin_light_ext = EXT_W'(r_fin_light);

    always_comb begin
        ref_val = '0;
        for (int i = 0; i < ppcc_pkg::HALF_N; i++) begin
            ref_val   = dark_half ? DIFF_W'(ppcc_pkg::REF_COUNTS[ppcc_pkg::HALF_N + i])
                                  : DIFF_W'(ppcc_pkg::REF_COUNTS[i]);
            n_diff[i] = (sel_count > ref_val) ? (sel_count - ref_val)
                                              : (ref_val - sel_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (d_free) begin
            r_d_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_diff        <= n_diff;
            r_d_dark_half <= dark_half;
            r_d_dark      <= fin_dark_ext[ppcc_pkg::TALLY_W-1:0];
            r_d_light     <= fin_light_ext[ppcc_pkg::TALLY_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Minimum search; on equal distance the lower index is kept.
    // ------------------------------------------------------------------
    logic [DIFF_W-1:0]            m01, m23, m45, m03;
    logic [IDX_W-1:0]             i01, i23, i45, i03, best;
    logic [ppcc_pkg::CLASS_W-1:0] n_class;

    always_comb begin
        m01 = (r_diff[1] < r_diff[0]) ? r_diff[1] : r_diff[0];
        i01 = (r_diff[1] < r_diff[0]) ? IDX_W'(1) : IDX_W'(0);
        m23 = (r_diff[3] < r_diff[2]) ? r_diff[3] : r_diff[2];
        i23 = (r_diff[3] < r_diff[2]) ? IDX_W'(3) : IDX_W'(2);
        m45 = (r_diff[5] < r_diff[4]) ? r_diff[5] : r_diff[4];
        i45 = (r_diff[5] < r_diff[4]) ? IDX_W'(5) : IDX_W'(4);
        m03 = (m23 < m01) ? m23 : m01;
        i03 = (m23 < m01) ? i23 : i01;
        best = (m45 < m03) ? i45 : i03;
        n_class = ppcc_pkg::CLASS_W'(best)
                + (r_d_dark_half ? ppcc_pkg::CLASS_W'(ppcc_pkg::HALF_N)
                                 : ppcc_pkg::CLASS_W'(0));
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [ppcc_pkg::CLASS_W-1:0] r_out_class;
    logic [ppcc_pkg::TALLY_W-1:0] r_out_dark, r_out_light;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_d_valid) begin
            r_out_class <= n_class;
            r_out_dark  <= r_d_dark;
            r_out_light <= r_d_light;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.piece_class  = r_out_class;
    assign o_res.dark_pixels  = r_out_dark;
    assign o_res.light_pixels = r_out_light;

endmodule

`default_nettype wire

FILE: tb/palette_pixel_count_classifier_test.sv
// ----------------------------------------------------------------------------
// Palette pixel count classifier testbench
// Streams frames of pixels into the classifier and checks each frame result
// against a predictor of the dark and light tallies and the frame class.
// Stimulus starts with directed frames and continues with random frames under
// several tolerance settings and with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_pixel_count_classifier_test;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_TICKS = 8;

    typedef struct packed {
        logic [ppcc_pkg::CLASS_W-1:0] piece_class;
        logic [ppcc_pkg::TALLY_W-1:0] dark_pixels;
        logic [ppcc_pkg::TALLY_W-1:0] light_pixels;
    } t_frame_result;

    // Predicts frame results from the accepted pixels and checks the results.
    class tally_scoreboard;
        logic [ppcc_pkg::TOL_W-1:0]       tolerance;
        logic [ppcc_pkg::COUNT_WIDTH-1:0] dark_tally;
        logic [ppcc_pkg::COUNT_WIDTH-1:0] light_tally;
        t_frame_result                    expected_q[$];
        int                               errors;

        function new();
            tolerance   = ppcc_pkg::MATCH_TOL_RESET;
            dark_tally  = '0;
            light_tally = '0;
            errors      = 0;
        endfunction

        function void set_register(int index, logic [ppcc_pkg::PDATA_W-1:0] value);
            if (index == ppcc_pkg::REG_MATCH_TOL) begin
                tolerance = value[ppcc_pkg::TOL_W-1:0];
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // A pixel matches when its squared distance is below the tolerance squared.
        function bit near_colour(ppcc_pkg::t_pixel p, ppcc_pkg::t_pixel c);
            int sum;
            int d;
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                d   = int'(p[k]) - int'(c[k]);
                sum = sum + d * d;
            end
            return sum < int'(tolerance) * int'(tolerance);
        endfunction

        // Index of the reference count closest to the tally; lowest index on a tie.
        function logic [ppcc_pkg::CLASS_W-1:0] nearest_ref(longint count, int first);
            int     best;
            longint best_d;
            longint ref_val;
            longint d;
            best   = first;
            best_d = 0;
            for (int i = first; i < first + ppcc_pkg::HALF_N; i++) begin
                ref_val = longint'(ppcc_pkg::REF_COUNTS[i]);
                d = (count > ref_val) ? count - ref_val : ref_val - count;
                if (i == first || d < best_d) begin
                    best_d = d;
                    best   = i;
                end
            end
            return ppcc_pkg::CLASS_W'(best);
        endfunction

        function void note_pixel(ppcc_pkg::t_pixel p, bit last);
            bit            dark;
            bit            light;
            t_frame_result r;
            dark  = 1'b0;
            light = 1'b0;
            for (int k = 0; k < ppcc_pkg::N_DARK; k++) begin
                if (near_colour(p, ppcc_pkg::DARK_COLOURS[k])) dark = 1'b1;
            end
            for (int k = 0; k < ppcc_pkg::N_LIGHT; k++) begin
                if (near_colour(p, ppcc_pkg::LIGHT_COLOURS[k])) light = 1'b1;
            end

            // Both tallies saturate at all ones.
            if (dark && dark_tally != '1) dark_tally++;
            if (light && light_tally != '1) light_tally++;

            // The frame end is counted first, then the larger tally picks a half.
            if (last) begin
                if (dark_tally > light_tally) begin
                    r.piece_class = nearest_ref(longint'(dark_tally), ppcc_pkg::HALF_N);
                end else begin
                    r.piece_class = nearest_ref(longint'(light_tally), 0);
                end
                r.dark_pixels  = ppcc_pkg::TALLY_W'(dark_tally);
                r.light_pixels = ppcc_pkg::TALLY_W'(light_tally);
                expected_q.insert(expected_q.size(), r);
                dark_tally  = '0;
                light_tally = '0;
            end
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected result: class %0d dark %0d light %0d",
                             got.piece_class, got.dark_pixels, got.light_pixels);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.piece_class !== want.piece_class || got.dark_pixels !== want.dark_pixels ||
                got.light_pixels !== want.light_pixels) begin
                errors++;
                if (errors <= 10) begin
                    $display("Mismatch: expected class %0d dark %0d light %0d,",
                             want.piece_class, want.dark_pixels, want.light_pixels,
                             " got class %0d dark %0d light %0d",
                             got.piece_class, got.dark_pixels, got.light_pixels);
                end
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [ppcc_pkg::PADDR_W-1:0] paddr;
    logic [ppcc_pkg::PDATA_W-1:0] pwdata;
    logic [ppcc_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    int src_idle_pct  = 36;
    int sink_idle_pct = 65;
    int cycle_count   = 0;

    tally_scoreboard board = new();

    ppcc_pix_if pix_ch();
    ppcc_res_if res_ch();

    palette_pixel_count_classifier DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: check every transfer and stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                board.check_result({res_ch.piece_class, res_ch.dark_pixels,
                                    res_ch.light_pixels});
            end
            res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Pixel near a reference colour, on a match boundary, or fully random.
    function automatic ppcc_pkg::t_pixel pick_pixel(int tol);
        ppcc_pkg::t_pixel base;
        ppcc_pkg::t_pixel p;
        int     mode;
        int     col;
        int     ch_sel;
        int     off;
        int     v;
        mode = $urandom_range(0, 99);
        if (mode >= 75) begin
            return ppcc_pkg::t_pixel'($urandom_range(0, 24'hFF_FFFF));
        end
        col = (mode < 40) ? $urandom_range(0, ppcc_pkg::N_DARK - 1) :
              (mode < 60) ? ppcc_pkg::N_DARK + $urandom_range(0, ppcc_pkg::N_LIGHT - 1) :
                            $urandom_range(0, ppcc_pkg::N_DARK + ppcc_pkg::N_LIGHT - 1);
        base   = (col < ppcc_pkg::N_DARK) ? ppcc_pkg::DARK_COLOURS[col]
                                          : ppcc_pkg::LIGHT_COLOURS[col - ppcc_pkg::N_DARK];
        ch_sel = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            if (mode < 60) begin
                off = int'($urandom_range(0, 2 * tol)) - tol;
            end else if (k == ch_sel) begin
                // Just inside or exactly on the tolerance radius.
                off = tol - int'($urandom_range(0, 1));
                if ($urandom_range(0, 1)) off = -off;
            end else begin
                off = 0;
            end
            v = int'(base[k]) + off;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            p[k] = v[ppcc_pkg::CHAN_W-1:0];
        end
        return p;
    endfunction

    // One pixel transfer, after a random number of idle cycles.
    task automatic send_pixel(ppcc_pkg::t_pixel p, bit last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.chan_zero  <= p[0];
        pix_ch.chan_one   <= p[1];
        pix_ch.chan_two   <= p[2];
        pix_ch.last_pixel <= last;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        board.note_pixel(p, last);
    endtask

    task automatic run_frame(int n);
        for (int i = 0; i < n; i++) begin
            send_pixel(pick_pixel(int'(board.tolerance)), i == n - 1);
        end
    endtask

    // Register write over APB once the block has drained.
    task automatic write_register(int index, logic [ppcc_pkg::PDATA_W-1:0] value);
        pix_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ppcc_pkg::PADDR_W'(4 * index);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(index, value);
    endtask

    initial begin
        int tol_plan [6];
        int pixels_sent;

        i_rst_n           <= 1'b0;
        pix_ch.valid      <= 1'b0;
        pix_ch.chan_zero  <= '0;
        pix_ch.chan_one   <= '0;
        pix_ch.chan_two   <= '0;
        pix_ch.last_pixel <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset tolerance: every reference colour, extremes and radius boundaries.
        for (int k = 0; k < ppcc_pkg::N_DARK; k++) begin
            send_pixel(ppcc_pkg::DARK_COLOURS[k], 1'b0);
        end
        for (int k = 0; k < ppcc_pkg::N_LIGHT; k++) begin
            send_pixel(ppcc_pkg::LIGHT_COLOURS[k], 1'b0);
        end
        send_pixel({8'd0, 8'd0, 8'd0}, 1'b0);
        send_pixel({8'd255, 8'd255, 8'd255}, 1'b0);
        send_pixel({8'd84, 8'd83, 8'd86}, 1'b0);
        send_pixel({8'd85, 8'd83, 8'd86}, 1'b0);
        send_pixel({8'd248, 8'd248, 8'd250}, 1'b0);
        send_pixel({8'd248, 8'd251, 8'd248}, 1'b1);

        // A frame of a single pixel.
        send_pixel(ppcc_pkg::LIGHT_COLOURS[1], 1'b1);

        // A write to an unmapped register must leave the tolerance alone.
        write_register(1, 32'h0000_0005);
        send_pixel(ppcc_pkg::DARK_COLOURS[3], 1'b1);

        // Zero tolerance matches nothing; the empty tie goes to the light half.
        write_register(ppcc_pkg::REG_MATCH_TOL, 32'd0);
        send_pixel(ppcc_pkg::DARK_COLOURS[0], 1'b0);
        send_pixel(ppcc_pkg::LIGHT_COLOURS[0], 1'b1);

        // A nonzero tally tie goes to the light half.
        write_register(ppcc_pkg::REG_MATCH_TOL, 32'd7);
        for (int i = 0; i < 5; i++) begin
            send_pixel(ppcc_pkg::DARK_COLOURS[i], 1'b0);
            send_pixel(ppcc_pkg::LIGHT_COLOURS[i % ppcc_pkg::N_LIGHT], i == 4);
        end

        // Random frames under several tolerances and idling patterns.
        tol_plan[0] = 7;
        tol_plan[1] = 255;
        tol_plan[2] = $urandom_range(1, 254);
        tol_plan[3] = 1;
        tol_plan[4] = $urandom_range(0, 255);
        tol_plan[5] = 255;
        for (int ph = 0; ph < 6; ph++) begin
            write_register(ppcc_pkg::REG_MATCH_TOL, tol_plan[ph]);
            case (ph / 2)
                0: begin
                    src_idle_pct  = 36;
                    sink_idle_pct = 65;
                end
                1: begin
                    src_idle_pct  = 65;
                    sink_idle_pct = 36;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            run_frame($urandom_range(60, 120));
            pixels_sent = 0;
            while (pixels_sent < 100) begin
                int len;
                len = $urandom_range(1, 24);
                run_frame(len);
                pixels_sent += len;
            end
        end

        pix_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
